/* hw/rtl/gst_pkg.sv */
package gst_pkg;

  // Default geometry
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int PHASE_FRAC_DEF  = 16;

  // Register fields
  localparam int INC_W  = 17;
  localparam int GAIN_W = 16;
  localparam int CFG_W  = 17;
  localparam int GAIN_FRAC = 24;

  localparam logic [INC_W-1:0]  INC_RESET  = 17'd4096;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd10486;

  typedef enum logic {
    CFG_PHASE_INC = 1'b0,
    CFG_LOOP_GAIN = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_I,
    ST_MUL_Q,
    ST_ACC,
    ST_MUL_G,
    ST_UPD
  } state_e;

endpackage

/* hw/rtl/gst_mul.sv */
module gst_mul #(
  parameter int AW = 34,
  parameter int BW = 17
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0] p_o
);

  logic signed [AW+BW-1:0] p_q;

  // Hold the product until the next issue
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= (AW+BW)'(a_i) * (AW+BW)'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

/* hw/rtl/gardner_symbol_timing_unit.sv */
// A sample that does not close a symbol is absorbed in the idle state and the block stays
// ready; a symbol sample passes through MUL_I, MUL_Q, ACC, MUL_G and UPD before its word
// goes into the output register, and no new sample is taken until then: three passes through
// the shared multiplier, the accumulate and the update; a full output register stalls it.
// Reset: timing state and history clear to zero, registers return to their defaults,
// the output register is empty and the block comes out of reset ready.
module gardner_symbol_timing_unit #(
  parameter int SAMPLE_BITS         = gst_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_FRACTION_BITS = gst_pkg::PHASE_FRAC_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [gst_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_q_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] symbol_i_o,
  output logic signed [SAMPLE_BITS-1:0] symbol_q_o
);

  localparam int SB   = SAMPLE_BITS;
  localparam int PFB  = PHASE_FRACTION_BITS;
  localparam int PhW  = PFB + 2;
  localparam int SW   = ((PhW > gst_pkg::INC_W + 1) ? PhW : gst_pkg::INC_W + 1) + 1;
  localparam int EW   = 2 * SB + 2;
  localparam int MB   = (SB > gst_pkg::GAIN_W + 1) ? SB : gst_pkg::GAIN_W + 1;
  localparam int PW   = EW + MB;
  localparam int AW   = PW + 1;
  localparam int GainShift = 2 * (SB - 1) + gst_pkg::GAIN_FRAC - PFB;

  localparam logic signed [SW-1:0] HalfSw = SW'(1) <<< (PFB - 1);
  localparam logic signed [SW-1:0] OneSw  = SW'(1) <<< PFB;
  localparam logic signed [AW-1:0] HalfAw = AW'(1) <<< (PFB - 1);
  localparam logic signed [AW-1:0] OneAw  = AW'(1) <<< PFB;

  gst_pkg::state_e state_q, state_d;

  logic [gst_pkg::INC_W-1:0]  inc_q;
  logic [gst_pkg::GAIN_W-1:0] gain_q;

  logic signed [PhW-1:0] phase_q;
  logic signed [SB-1:0]  prev_i_q, prev_q_q, mid_i_q, mid_q_q;
  logic                  mid_taken_q;
  logic signed [SB-1:0]  s_i_q, s_q_q;
  logic signed [SW-1:0]  ph_q;
  logic signed [EW-1:0]  err_q;
  logic                  out_valid_q;
  logic signed [SB-1:0]  sym_i_q, sym_q_q;

  logic                  accept;
  logic                  emit;
  logic                  mul_en;
  logic signed [EW-1:0]  mul_a;
  logic signed [MB-1:0]  mul_b;
  logic signed [PW-1:0]  prod;
  logic signed [SW-1:0]  ph_sum;
  logic signed [SB:0]    diff_i, diff_q;
  logic signed [PW-1:0]  corr;
  logic signed [AW-1:0]  ph_new;
  logic signed [AW-1:0]  ph_clamped;

  assign in_ready_o = (state_q == gst_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign emit       = (state_q == gst_pkg::ST_UPD) && (!out_valid_q || out_ready_i);

  assign ph_sum = SW'(phase_q) + $signed(SW'(inc_q));
  assign diff_i = (SB+1)'(prev_i_q) - (SB+1)'(s_i_q);
  assign diff_q = (SB+1)'(prev_q_q) - (SB+1)'(s_q_q);

  // Arithmetic shift gives the floor of gain * error
  assign corr   = prod >>> GainShift;
  assign ph_new = AW'(ph_q) - OneAw + AW'(corr);

  always_comb begin
    if (ph_new < -HalfAw) begin
      ph_clamped = -HalfAw;
    end else if (ph_new > HalfAw) begin
      ph_clamped = HalfAw;
    end else begin
      ph_clamped = ph_new;
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a  = err_q;
    mul_b  = MB'({1'b0, gain_q});
    case (state_q)
      gst_pkg::ST_MUL_I: begin
        mul_en = 1'b1;
        mul_a  = EW'(diff_i);
        mul_b  = MB'(mid_i_q);
      end
      gst_pkg::ST_MUL_Q: begin
        mul_en = 1'b1;
        mul_a  = EW'(diff_q);
        mul_b  = MB'(mid_q_q);
      end
      gst_pkg::ST_MUL_G: begin
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  gst_mul #(
    .AW (EW),
    .BW (MB)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      gst_pkg::ST_IDLE: begin
        if (accept && (command_i != gst_pkg::CMD_CLEAR) && (ph_sum >= OneSw)) begin
          state_d = gst_pkg::ST_MUL_I;
        end
      end
      gst_pkg::ST_MUL_I: state_d = gst_pkg::ST_MUL_Q;
      gst_pkg::ST_MUL_Q: state_d = gst_pkg::ST_ACC;
      gst_pkg::ST_ACC:   state_d = gst_pkg::ST_MUL_G;
      gst_pkg::ST_MUL_G: state_d = gst_pkg::ST_UPD;
      gst_pkg::ST_UPD: begin
        if (emit) begin
          state_d = gst_pkg::ST_IDLE;
        end
      end
      default: state_d = gst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gst_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q  <= gst_pkg::INC_RESET;
      gain_q <= gst_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gst_pkg::CFG_PHASE_INC: inc_q  <= cfg_data_i[gst_pkg::INC_W-1:0];
        gst_pkg::CFG_LOOP_GAIN: gain_q <= cfg_data_i[gst_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Timing state and history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      prev_i_q    <= '0;
      prev_q_q    <= '0;
      mid_i_q     <= '0;
      mid_q_q     <= '0;
      mid_taken_q <= 1'b0;
    end else if (accept) begin
      if (command_i == gst_pkg::CMD_CLEAR) begin
        phase_q     <= '0;
        prev_i_q    <= '0;
        prev_q_q    <= '0;
        mid_i_q     <= '0;
        mid_q_q     <= '0;
        mid_taken_q <= 1'b0;
      end else begin
        if (!mid_taken_q && (ph_sum >= HalfSw)) begin
          mid_i_q     <= sample_i_i;
          mid_q_q     <= sample_q_i;
          mid_taken_q <= 1'b1;
        end
        if (ph_sum < OneSw) begin
          phase_q <= PhW'(ph_sum);
        end
      end
    end else if (emit) begin
      phase_q     <= PhW'(ph_clamped);
      prev_i_q    <= s_i_q;
      prev_q_q    <= s_q_q;
      mid_taken_q <= 1'b0;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_i_q <= sample_i_i;
      s_q_q <= sample_q_i;
      ph_q  <= ph_sum;
    end
    case (state_q)
      gst_pkg::ST_MUL_Q: err_q <= EW'(prod);
      gst_pkg::ST_ACC:   err_q <= err_q + EW'(prod);
      default: ;
    endcase
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      sym_i_q <= s_i_q;
      sym_q_q <= s_q_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign symbol_i_o  = sym_i_q;
  assign symbol_q_o  = sym_q_q;

endmodule
